### design/tmph_pkg.sv
// Shared types and sizing constants for the trimmed mean filter with peak hold.
// Used by the filter cells, the peak cells and the top level; depends on nothing.
package tmph_pkg;

    localparam int FILTER_TAPS  = 5;
    localparam int PEAK_HISTORY = 5;
    localparam int PEAK_WINDOW  = 3;

    localparam int DATA_W    = 16;
    localparam int SUM_W     = DATA_W + $clog2(FILTER_TAPS);
    localparam int TRIM_DIV  = FILTER_TAPS - 2;
    localparam int DIV_SHIFT = SUM_W + $clog2(TRIM_DIV);
    localparam int MUL_W     = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV_MULT =
        MUL_W'((2 ** DIV_SHIFT + TRIM_DIV - 1) / TRIM_DIV);

    localparam int WIN_KEPT = PEAK_WINDOW - 1;
    localparam int WIN_MID  = (PEAK_WINDOW - 1) / 2;

    typedef logic [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        t_data            lo;
        t_data            hi;
    } t_tap_agg;

endpackage

### design/tmph_tap_cell.sv
// One cell of the sample chain: holds one sample and folds it into the running
// sum, minimum and maximum passed along the chain. Depends on tmph_pkg.
module tmph_tap_cell
    import tmph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_shift,
    input  t_data    i_data,
    input  t_tap_agg i_agg,
    output t_data    o_data,
    output t_tap_agg o_agg
);

    t_data r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_shift) begin
            r_val <= i_data;
        end
    end

    always_comb begin
        o_data    = r_val;
        o_agg.sum = i_agg.sum + SUM_W'(r_val);
        o_agg.lo  = (r_val < i_agg.lo) ? r_val : i_agg.lo;
        o_agg.hi  = (r_val > i_agg.hi) ? r_val : i_agg.hi;
    end

endmodule

### design/tmph_peak_cell.sv
// One cell of the peak history chain: holds one detected peak and passes the
// running maximum along the chain. Depends on tmph_pkg.
module tmph_peak_cell
    import tmph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_data i_data,
    input  t_data i_max,
    output t_data o_data,
    output t_data o_max
);

    t_data r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_shift) begin
            r_val <= i_data;
        end
    end

    assign o_data = r_val;
    assign o_max  = (r_val > i_max) ? r_val : i_max;

endmodule

### design/trimmed_mean_peak_hold.sv
// Top level of the trimmed mean filter with peak hold.
// Instantiates tmph_tap_cell and tmph_peak_cell; depends on tmph_pkg.
//
// Each transfer on the input stream carries one raw sample. Each accepted
// sample produces exactly one transfer on the output stream, in order, with
// the trimmed mean of the last five samples, the largest of the last five
// detected peaks and a flag that marks the transfer that completed a peak.
// The block is a five-stage pipeline: the sample chain and its running
// sum, minimum and maximum, the trimmed sum, the multiply by the reciprocal
// of three, the peak window test with the peak chain, and the output
// register. One sample per cycle is taken in steady state while the receiver
// keeps taking results. Each stage has its own valid bit, so an empty stage
// still takes data while the receiver stalls; the input stops only when every
// stage is full. Reset clears all samples, the peak window and the peak
// history to zero and empties the pipeline. The zero entries take part in
// the first results.
module trimmed_mean_peak_hold
    import tmph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [15:0] sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [15:0] filtered, [31:16] highest_peak
    output logic        o_m_tuser   // [0] peak_found
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic move2, move3, move4, move5;

    assign rdy5  = !r_v5 || i_m_tready;
    assign rdy4  = !r_v4 || rdy5;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign move2 = r_v1 && rdy2;
    assign move3 = r_v2 && rdy3;
    assign move4 = r_v3 && rdy4;
    assign move5 = r_v4 && rdy5;

    assign o_s_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    logic     accept;
    t_data    tap_data [0:FILTER_TAPS-1];
    t_tap_agg tap_agg  [0:FILTER_TAPS];

    assign accept      = i_s_tvalid && rdy1;
    assign tap_data[0] = i_s_tdata;
    assign tap_agg[0]  = '{sum: '0, lo: '1, hi: '0};

    for (genvar g = 0; g < FILTER_TAPS; g++) begin : g_tap
        if (g < FILTER_TAPS - 1) begin : g_mid
            tmph_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_data  (tap_data[g]),
                .i_agg   (tap_agg[g]),
                .o_data  (tap_data[g+1]),
                .o_agg   (tap_agg[g+1])
            );
        end else begin : g_end
            tmph_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_data  (tap_data[g]),
                .i_agg   (tap_agg[g]),
                .o_data  (),
                .o_agg   (tap_agg[g+1])
            );
        end
    end

    logic [SUM_W-1:0]  r_trim;
    logic [PROD_W-1:0] r_prod;
    t_tap_agg          agg;

    assign agg = tap_agg[FILTER_TAPS];

    always_ff @(posedge i_clk) begin
        if (move2) begin
            r_trim <= agg.sum - SUM_W'(agg.hi) - SUM_W'(agg.lo);
        end
        if (move3) begin
            r_prod <= PROD_W'(r_trim) * PROD_W'(DIV_MULT);
        end
    end

    t_data              filt;
    t_data              r_win [0:WIN_KEPT-1];
    t_data              win   [0:WIN_KEPT];
    logic [WIN_KEPT-1:0] win_ok;
    logic               found;

    assign filt = r_prod[DIV_SHIFT +: DATA_W];

    always_comb begin
        for (int i = 0; i < WIN_KEPT; i++) begin
            win[i] = r_win[i];
        end
        win[WIN_KEPT] = filt;
        for (int i = 0; i < WIN_KEPT; i++) begin
            if (i < WIN_MID) begin
                win_ok[i] = win[i] < win[i+1];
            end else begin
                win_ok[i] = win[i] >= win[i+1];
            end
        end
        found = &win_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_KEPT; i++) begin
                r_win[i] <= '0;
            end
        end else if (move4) begin
            for (int i = 0; i < WIN_KEPT; i++) begin
                r_win[i] <= win[i+1];
            end
        end
    end

    logic  pk_shift;
    t_data pk_data [0:PEAK_HISTORY-1];
    t_data pk_max  [0:PEAK_HISTORY];

    assign pk_shift   = move4 && found;
    assign pk_data[0] = win[WIN_MID];
    assign pk_max[0]  = '0;

    for (genvar g = 0; g < PEAK_HISTORY; g++) begin : g_peak
        if (g < PEAK_HISTORY - 1) begin : g_mid
            tmph_peak_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (pk_shift),
                .i_data  (pk_data[g]),
                .i_max   (pk_max[g]),
                .o_data  (pk_data[g+1]),
                .o_max   (pk_max[g+1])
            );
        end else begin : g_end
            tmph_peak_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (pk_shift),
                .i_data  (pk_data[g]),
                .i_max   (pk_max[g]),
                .o_data  (),
                .o_max   (pk_max[g+1])
            );
        end
    end

    t_data r_filt;
    logic  r_found;
    t_data r_out_filt;
    t_data r_out_peak;
    logic  r_out_found;

    always_ff @(posedge i_clk) begin
        if (move4) begin
            r_filt  <= filt;
            r_found <= found;
        end
        if (move5) begin
            r_out_filt  <= r_filt;
            r_out_found <= r_found;
            r_out_peak  <= pk_max[PEAK_HISTORY];
        end
    end

    assign o_m_tvalid = r_v5;
    assign o_m_tdata  = {r_out_peak, r_out_filt};
    assign o_m_tuser  = r_out_found;

endmodule

### design/tmph_checker.sv
// Port-level checks for the trimmed mean filter with peak hold, bound to the
// top level. Depends only on the top level's ports.
module tmph_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic        xfer;
    logic [15:0] r_last_peak;
    logic        r_last_found;

    assign xfer = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_peak  <= '0;
            r_last_found <= 1'b0;
        end else if (xfer) begin
            r_last_peak  <= o_m_tdata[31:16];
            r_last_found <= o_m_tuser;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("Stalled output transfer changed.");

    a_peak_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !o_m_tuser |-> o_m_tdata[31:16] == r_last_peak)
        else $error("Held peak changed without a new peak.");

    a_peak_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && r_last_found |-> !o_m_tuser)
        else $error("Peaks reported on two transfers in a row.");

endmodule

bind trimmed_mean_peak_hold tmph_checker u_tmph_checker (.*);
